### rtl/core/assert_macros.svh
// Assertion macros shared by the min/max auto-scale RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MMAS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mmas assertion failed");

// Checked on every rising clock edge, also during reset.
`define MMAS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mmas assertion failed");

`endif

### rtl/core/mmas_pkg.sv
// Package with the shared types of the min/max auto-scale block.
`default_nettype none

package mmas_pkg;

    typedef enum logic {
        MODE_MEASURE = 1'b0,
        MODE_APPLY   = 1'b1
    } mode_t;

    // Flags latched at the end of a measure pass.
    typedef struct packed {
        logic identity;
        logic flat;
    } frame_flags_t;

endpackage

`default_nettype wire

### rtl/core/min_max_auto_scale_unit.sv
// Top level of the min/max auto-scale block: request control and result register.
// Usage:
// Input requests carry mode, sample and last on in_valid/in_ready. A measure
// request (mode 0) updates the running minimum and maximum and gives no
// result; the one marked last latches the frame minimum, range and flags.
// An apply request (mode 1) gives exactly one result on out_valid/out_ready:
// value, the sample stretched to 0..1.0, and end_of_frame, a copy of last.
// An apply request on the identity frame, a flat frame or a sample below the
// frame minimum or at or above minimum plus range takes its result directly;
// any other goes through the restoring divider, which produces one quotient bit
// per cycle. One request is in flight at a time, so an apply request occupies
// the block until its result has moved to the result register.
// The result register lets the next request enter while a result waits; when
// the receiver stalls, a finished result waits in the block and in_ready stays
// low until the result register is free.
// Reset clears all control state and restores the identity frame, so apply
// requests before any measure pass return the clamped sample.
`default_nettype none
`include "assert_macros.svh"

module min_max_auto_scale_unit
    import mmas_pkg::*;
#(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [FRACTION_BITS:0]             value,
    output logic                               end_of_frame
);

    localparam int CW = ((SAMPLE_BITS > FRACTION_BITS + 2) ? SAMPLE_BITS
                                                           : FRACTION_BITS + 2) + 1;
    localparam logic [CW-1:0] ONE_CW =
        {{(CW-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS:0] ONE_VAL  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS:0] HALF_VAL = {2'b01, {(FRACTION_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } state_t;

    state_t                  state_reg;
    logic [FRACTION_BITS:0]  res_reg;
    logic                    eof_reg;
    logic [FRACTION_BITS:0]  value_reg;
    logic                    end_of_frame_reg;
    logic                    out_valid_reg;

    logic                          accept;
    logic                          meas_en;
    logic                          apply_en;
    logic signed [SAMPLE_BITS-1:0] frame_min;
    logic        [SAMPLE_BITS-1:0] frame_range;
    frame_flags_t                  frame_flags;
    logic        [CW-1:0]          s_ext;
    logic        [SAMPLE_BITS:0]   diff;
    logic                          need_div;
    logic [FRACTION_BITS:0]        direct_val;
    logic                          div_start;
    logic                          div_done;
    logic [FRACTION_BITS-1:0]      quotient;
    logic                          out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign meas_en  = accept && (mode_t'(mode) == MODE_MEASURE);
    assign apply_en = accept && (mode_t'(mode) == MODE_APPLY);

    // The held result moves to the output register when that register is free.
    assign out_load = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        s_ext = {{(CW-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
        diff  = {sample[SAMPLE_BITS-1], sample} - {frame_min[SAMPLE_BITS-1], frame_min};
        need_div   = 1'b0;
        direct_val = '0;
        if (frame_flags.identity)
        begin
            if (sample[SAMPLE_BITS-1])
                direct_val = '0;
            else if ($signed(s_ext) > $signed(ONE_CW))
                direct_val = ONE_VAL;
            else
                direct_val = s_ext[FRACTION_BITS:0];
        end
        else if (frame_flags.flat)
            direct_val = HALF_VAL;
        else if (diff[SAMPLE_BITS])
            direct_val = '0;
        else if (diff[SAMPLE_BITS-1:0] >= frame_range)
            direct_val = ONE_VAL;
        else
            need_div = 1'b1;
    end

    assign div_start = apply_en && need_div;

    mmas_measure #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_measure (
        .clk         (clk),
        .rst_n       (rst_n),
        .meas_en     (meas_en),
        .sample      (sample),
        .last        (last),
        .frame_min   (frame_min),
        .frame_range (frame_range),
        .frame_flags (frame_flags)
    );

    mmas_divider #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (diff[SAMPLE_BITS-1:0]),
        .den      (frame_range),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            res_reg          <= '0;
            eof_reg          <= 1'b0;
            value_reg        <= '0;
            end_of_frame_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (apply_en)
                    begin
                        eof_reg <= last;
                        res_reg <= direct_val;
                        state_reg <= need_div ? S_DIV : S_HOLD;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= {1'b0, quotient};
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_load)
                    begin
                        value_reg        <= res_reg;
                        end_of_frame_reg <= eof_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign end_of_frame = end_of_frame_reg;

    // The divider only finishes while the control waits for it.
    `MMAS_ASSERT(a_done_in_div, div_done |-> (state_reg == S_DIV))
    // A new result is loaded only from the hold state.
    `MMAS_ASSERT(a_load_from_hold, $rose(out_valid_reg) |-> ($past(state_reg) == S_HOLD))
    // A shown result never exceeds 1.0.
    `MMAS_ASSERT(a_value_range, out_valid_reg |-> (value_reg <= ONE_VAL))

endmodule

`default_nettype wire

### rtl/core/mmas_measure.sv
// Running minimum and maximum tracker with the per-frame latches.
`default_nettype none
`include "assert_macros.svh"

module mmas_measure
    import mmas_pkg::*;
#(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          meas_en,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last,
    output logic signed [SAMPLE_BITS-1:0]      frame_min,
    output logic        [SAMPLE_BITS-1:0]      frame_range,
    output frame_flags_t                       frame_flags
);

    localparam int CW = ((SAMPLE_BITS > FRACTION_BITS + 2) ? SAMPLE_BITS
                                                           : FRACTION_BITS + 2) + 1;
    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [CW-1:0] ONE_CW =
        {{(CW-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] ONE_RANGE = SAMPLE_BITS'(ONE_CW);

    logic signed [SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic signed [SAMPLE_BITS-1:0] run_max_reg, run_max_next;
    logic signed [SAMPLE_BITS-1:0] frame_min_reg, frame_min_next;
    logic        [SAMPLE_BITS-1:0] frame_range_reg, frame_range_next;
    frame_flags_t                  flags_reg, flags_next;

    logic signed [SAMPLE_BITS-1:0] new_min;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic        [SAMPLE_BITS:0]   span;
    logic        [CW-1:0]          max_ext;

    always_comb
    begin
        new_min = (sample < run_min_reg) ? sample : run_min_reg;
        new_max = (sample > run_max_reg) ? sample : run_max_reg;
        // The current sample enters both, so the span is never negative.
        span    = {new_max[SAMPLE_BITS-1], new_max} - {new_min[SAMPLE_BITS-1], new_min};
        max_ext = {{(CW-SAMPLE_BITS){new_max[SAMPLE_BITS-1]}}, new_max};

        run_min_next     = run_min_reg;
        run_max_next     = run_max_reg;
        frame_min_next   = frame_min_reg;
        frame_range_next = frame_range_reg;
        flags_next       = flags_reg;
        if (meas_en)
        begin
            if (last)
            begin
                frame_min_next      = new_min;
                frame_range_next    = span[SAMPLE_BITS-1:0];
                flags_next.identity = (new_min == '0) && (max_ext == ONE_CW);
                flags_next.flat     = (span[SAMPLE_BITS-1:0] == '0);
                run_min_next        = SMAX;
                run_max_next        = SMIN;
            end
            else
            begin
                run_min_next = new_min;
                run_max_next = new_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg     <= SMAX;
            run_max_reg     <= SMIN;
            frame_min_reg   <= '0;
            frame_range_reg <= ONE_RANGE;
            flags_reg       <= '{identity: 1'b1, flat: 1'b0};
        end
        else
        begin
            run_min_reg     <= run_min_next;
            run_max_reg     <= run_max_next;
            frame_min_reg   <= frame_min_next;
            frame_range_reg <= frame_range_next;
            flags_reg       <= flags_next;
        end
    end

    assign frame_min   = frame_min_reg;
    assign frame_range = frame_range_reg;
    assign frame_flags = flags_reg;

    // A zero-range frame can never be the identity frame.
    `MMAS_ASSERT_ALWAYS(a_flat_not_identity, !(flags_reg.flat && flags_reg.identity))

endmodule

`default_nettype wire

### rtl/core/mmas_divider.sv
// Restoring fraction divider that produces one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"

module mmas_divider
    import mmas_pkg::*;
#(
    parameter int SAMPLE_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [SAMPLE_BITS-1:0]   num,
    input  wire logic [SAMPLE_BITS-1:0]   den,
    output logic                          done,
    output logic [FRACTION_BITS-1:0]      quotient
);

    localparam int CNTW = $clog2(FRACTION_BITS);
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(FRACTION_BITS - 1);

    logic [SAMPLE_BITS-1:0]   rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]   den_reg, den_next;
    logic [FRACTION_BITS-1:0] q_reg, q_next;
    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [SAMPLE_BITS:0]     shifted;
    logic [SAMPLE_BITS:0]     trial;
    logic                     q_bit;

    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        trial   = shifted - {1'b0, den_reg};
        q_bit   = (shifted >= {1'b0, den_reg});

        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits the sample width.
            rem_next = q_bit ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            q_next   = {q_reg[FRACTION_BITS-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            q_reg    <= q_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    `MMAS_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg))
    `MMAS_ASSERT(a_no_restart_busy, busy_reg |-> !start)

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the min/max auto-scale block with random frames and backpressure.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmas_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 16;
    localparam longint UNITY   = longint'(1) << FRAC_W;
    localparam longint HALF    = longint'(1) << (FRAC_W - 1);
    localparam longint SMAX    = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SMIN    = -(longint'(1) << (SAMPLE_W - 1));
    localparam longint FULL_SPAN = (longint'(1) << SAMPLE_W) - 1;

    typedef struct {
        logic [FRAC_W:0] val;
        logic            eof;
    } scaled_t;

    typedef enum int {
        FK_WIDE,
        FK_NARROW,
        FK_UNIT,
        FK_FLAT
    } frame_kind_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    mode_t                      mode = MODE_MEASURE;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [FRAC_W:0]            value;
    logic                       end_of_frame;

    // Predicted block state.
    longint run_lo = SMAX;
    longint run_hi = SMIN;
    longint frm_lo = 0;
    longint frm_span = UNITY;
    bit     is_identity = 1'b1;
    bit     is_flat = 1'b0;

    scaled_t scaled_q[$];
    int      errors = 0;
    int      sent_count = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      hold_req = 0;

    min_max_auto_scale_unit #(
        .SAMPLE_BITS  (SAMPLE_W),
        .FRACTION_BITS(FRAC_W)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .sample      (sample),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .end_of_frame(end_of_frame)
    );

    always #4ns clk = ~clk;

    function automatic longint rand_full();
        logic [SAMPLE_W-1:0] raw;
        raw = SAMPLE_W'($urandom);
        return longint'($signed(raw));
    endfunction

    // Offers one request, waits for it to be taken, then updates the predicted state.
    task automatic offer_sample(mode_t m, longint s, logic l);
        scaled_t exp_r;
        longint  d;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        sample   <= SAMPLE_W'(s);
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;

        if (m == MODE_MEASURE)
        begin
            if (s < run_lo)
                run_lo = s;
            if (s > run_hi)
                run_hi = s;
            if (l)
            begin
                frm_lo      = run_lo;
                frm_span    = (run_hi >= run_lo) ? run_hi - run_lo : 0;
                is_identity = (run_lo == 0 && run_hi == UNITY);
                is_flat     = (frm_span == 0);
                run_lo      = SMAX;
                run_hi      = SMIN;
            end
        end
        else
        begin
            d = s - frm_lo;
            if (is_identity)
                exp_r.val = (s < 0) ? '0 : (s > UNITY) ? (FRAC_W+1)'(UNITY) : (FRAC_W+1)'(s);
            else if (is_flat)
                exp_r.val = (FRAC_W+1)'(HALF);
            else if (d < 0)
                exp_r.val = '0;
            else if (d >= frm_span)
                exp_r.val = (FRAC_W+1)'(UNITY);
            else
                exp_r.val = (FRAC_W+1)'((d << FRAC_W) / frm_span);
            exp_r.eof = l;
            scaled_q.push_back(exp_r);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (scaled_q.size() != 0)
            @(posedge clk);
    endtask

    // Apply before any measure pass must return the clamped sample.
    task automatic test_identity_after_reset();
        offer_sample(MODE_APPLY, SMIN, 1'b0);
        offer_sample(MODE_APPLY, 0, 1'b0);
        offer_sample(MODE_APPLY, HALF, 1'b0);
        offer_sample(MODE_APPLY, UNITY + 1, 1'b0);
        offer_sample(MODE_APPLY, SMAX, 1'b1);
    endtask

    task automatic test_special_frames();
        // Widest possible range.
        offer_sample(MODE_MEASURE, SMAX, 1'b0);
        offer_sample(MODE_MEASURE, SMIN, 1'b1);
        offer_sample(MODE_APPLY, SMIN, 1'b0);
        offer_sample(MODE_APPLY, SMAX, 1'b0);
        offer_sample(MODE_APPLY, 0, 1'b1);
        // Flat frame.
        offer_sample(MODE_MEASURE, 1000, 1'b1);
        offer_sample(MODE_APPLY, SMIN, 1'b0);
        offer_sample(MODE_APPLY, SMAX, 1'b1);
        // Measured identity frame.
        offer_sample(MODE_MEASURE, 0, 1'b0);
        offer_sample(MODE_MEASURE, UNITY, 1'b0);
        offer_sample(MODE_MEASURE, 30000, 1'b1);
        offer_sample(MODE_APPLY, -5, 1'b0);
        offer_sample(MODE_APPLY, 70000, 1'b0);
        offer_sample(MODE_APPLY, 1234, 1'b1);
        // Samples below the minimum, at min plus range, above it and inside.
        offer_sample(MODE_MEASURE, 100, 1'b0);
        offer_sample(MODE_MEASURE, 5100, 1'b1);
        offer_sample(MODE_APPLY, 50, 1'b0);
        offer_sample(MODE_APPLY, 5100, 1'b0);
        offer_sample(MODE_APPLY, 6000, 1'b0);
        offer_sample(MODE_APPLY, 2000, 1'b1);
    endtask

    task automatic test_random_frames(int items, int idle, int stall);
        frame_kind_t kind;
        longint      base;
        longint      spread;
        longint      lo_g;
        longint      hi_g;
        longint      s;
        int          n;
        int          start;
        idle_pct  = idle;
        stall_pct <= stall;
        start     = sent_count;
        while (sent_count - start < items)
        begin
            kind = frame_kind_t'($urandom_range(3));
            case (kind)
                FK_WIDE:
                begin
                    base   = SMIN;
                    spread = FULL_SPAN;
                end
                FK_NARROW:
                begin
                    spread = longint'(1) << $urandom_range(0, 20);
                    base   = SMIN + $urandom_range(0, 32'(FULL_SPAN - spread));
                end
                FK_UNIT:
                begin
                    base   = 0;
                    spread = UNITY;
                end
                default:
                begin
                    base   = rand_full();
                    spread = 0;
                end
            endcase

            // Measure pass; now and then the last marker is left out on purpose.
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                if (kind == FK_UNIT && i == 0)
                    s = 0;
                else if (kind == FK_UNIT && i == 1)
                    s = UNITY;
                else
                    s = base + $urandom_range(0, 32'(spread));
                offer_sample(MODE_MEASURE, s, (i == n - 1) && ($urandom_range(9) != 0));
            end

            lo_g = base - spread / 4 - 2;
            hi_g = base + spread + spread / 4 + 2;
            if (lo_g < SMIN)
                lo_g = SMIN;
            if (hi_g > SMAX)
                hi_g = SMAX;
            repeat ($urandom_range(1, 3))
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(19) == 0)
                        s = rand_full();
                    else
                        s = lo_g + $urandom_range(0, 32'(hi_g - lo_g));
                    offer_sample(MODE_APPLY, s, i == n - 1);
                end
            end

            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 4))
                    offer_sample(mode_t'($urandom_range(1)), rand_full(), 1'($urandom_range(1)));
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct <= 0;
        hold_req  <= 300;
        for (int i = 0; i < 12; i++)
            offer_sample(MODE_APPLY, rand_full(), i == 11);
        wait_drained();
    endtask

    // Receiver ready, with random stalls and one-shot long hold-offs.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                n = hold_req;
                hold_req  <= 0;
                out_ready <= 1'b0;
                for (int i = 0; i < n; i++)
                    @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        scaled_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (scaled_q.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d end_of_frame=%0b",
                         $time, value, end_of_frame);
                errors++;
            end
            else
            begin
                want = scaled_q.pop_front();
                if (value !== want.val)
                begin
                    $display("%0t: value expected %0d actual %0d", $time, want.val, value);
                    errors++;
                end
                if (end_of_frame !== want.eof)
                begin
                    $display("%0t: end_of_frame expected %0b actual %0b",
                             $time, want.eof, end_of_frame);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_identity_after_reset();
        test_special_frames();
        test_random_frames(215, 0, 0);
        test_random_frames(215, 59, 0);
        test_backpressure();
        test_random_frames(215, 0, 59);
        test_random_frames(215, 31, 31);

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && scaled_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mmas_pkg.sv
rtl/core/mmas_measure.sv
rtl/core/mmas_divider.sv
rtl/core/min_max_auto_scale_unit.sv
test/tb.sv
